FILE: sv/ufmc_pkg.sv
// Shared constants and codes for the union-find maze carver.
`default_nettype none
package ufmc_pkg;
  localparam int DEFAULT_MAX_SIDE = 32;
  localparam int RESET_SIDE = 4;
  localparam int CFG_W = 6;
  localparam int OPC_W = 2;
  localparam int WALL_IDX_W = 12;
  localparam int STATUS_W = 3;

  localparam logic [OPC_W-1:0] OP_CARVE   = 2'd0;
  localparam logic [OPC_W-1:0] OP_READ    = 2'd1;
  localparam logic [OPC_W-1:0] OP_RESTART = 2'd2;

  localparam logic [STATUS_W-1:0] ST_CARVED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDARY  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OPEN      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAME_SET  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_RESTARTED = 3'd6;
endpackage
`default_nettype wire

FILE: sv/ufmc_rem.sv
// Bit-serial restoring remainder unit: wall index modulo the grid side.
`default_nettype none
module ufmc_rem #(
  parameter int MAX_SIDE = ufmc_pkg::DEFAULT_MAX_SIDE
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [ufmc_pkg::WALL_IDX_W-1:0]       dividend,
  input  wire logic [$clog2(MAX_SIDE+1)-1:0]         divisor,
  output logic                                       done,
  output logic                                       rem_zero
);
  import ufmc_pkg::*;

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CNT_W = $clog2(WALL_IDX_W + 1);

  logic [WALL_IDX_W-1:0] shreg;
  logic [SIDE_W-1:0]     rem;
  logic [SIDE_W:0]       trial;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;

  // One quotient bit per cycle; the partial remainder always stays below the divisor.
  assign trial = {rem, shreg[WALL_IDX_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WALL_IDX_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[WALL_IDX_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= SIDE_W'(trial - {1'b0, divisor});
      end else begin
        rem <= SIDE_W'(trial);
      end
    end
  end

  assign rem_zero = (rem == '0);
endmodule
`default_nettype wire

FILE: sv/union_find_maze_carver.sv
// Top level of the union-find maze carver: sequencer, disjoint-set and wall memories.
`default_nettype none
// The block keeps a square maze of grid_side cells per side (clamped to 2..MAX_SIDE) and
// a disjoint-set table over its cells. Each request on the slave stream returns exactly
// one result on the master stream, unless a configuration write cuts it short. A carve
// request runs the wall index through a bit-serial remainder unit for the boundary test,
// reads the wall bit, then walks and compresses the parent chains of both cells in the
// parent memory, links the roots and opens the wall; a carve takes longer while chains
// are deep. A read request only reads the wall bit before its result is loaded. A
// restart request, a configuration write and reset each start a clearing pass over the
// memories, during which no request is accepted. The block accepts one request at a
// time; a finished result waits in the output register while the next request is taken.
module union_find_maze_carver #(
  parameter int MAX_SIDE = ufmc_pkg::DEFAULT_MAX_SIDE
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ufmc_pkg::CFG_W-1:0] cfg_wr_data,    // grid_side
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [15:0]                s_axis_tdata,   // wall_index[11:0], join_direction[12]
  input  wire logic [1:0]                 s_axis_tuser,   // opcode[1:0]
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [7:0]                      m_axis_tdata    // status[2:0], wall_open[3], maze_done[4]
);
  import ufmc_pkg::*;

  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int CELL_CAP  = MAX_SIDE * MAX_SIDE + 1;
  localparam int WALL_CAP  = 2 * MAX_SIDE * MAX_SIDE + 1;
  localparam int CELL_W    = $clog2(CELL_CAP);
  localparam int WALL_W    = $clog2(WALL_CAP);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_REM    = 4'd2;
  localparam logic [3:0] S_WCHK_A = 4'd3;
  localparam logic [3:0] S_WCHK_D = 4'd4;
  localparam logic [3:0] S_F1_A   = 4'd5;
  localparam logic [3:0] S_F1_D   = 4'd6;
  localparam logic [3:0] S_F2_A   = 4'd7;
  localparam logic [3:0] S_F2_D   = 4'd8;
  localparam logic [3:0] S_LINK   = 4'd9;
  localparam logic [3:0] S_WRD    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  // Configuration and derived sizes.
  logic [CFG_W-1:0]      grid_side;
  logic [SIDE_W-1:0]     side;
  logic [2*SIDE_W-1:0]   side_sq;
  logic [CELL_W-1:0]     nn;
  logic [WALL_W-1:0]     nn2;
  logic [WALL_W-1:0]     nn2mn;

  // Sequencer state and request registers.
  logic [3:0]            state;
  logic [WALL_IDX_W-1:0] w;
  logic                  dir;
  logic [STATUS_W-1:0]   status;
  logic                  pending;
  logic [WALL_W-1:0]     sweep;
  logic                  second;
  logic [CELL_W-1:0]     cell_start;
  logic [CELL_W-1:0]     cell_b;
  logic [CELL_W-1:0]     root;
  logic [CELL_W-1:0]     root_a;
  logic [CELL_W-1:0]     cur;
  logic [CELL_W-1:0]     join_count;
  logic                  done_flag;

  // Memories.
  logic [CELL_W-1:0]     parent_mem [CELL_CAP];
  logic                  wall_mem [WALL_CAP];
  logic [CELL_W-1:0]     paddr;
  logic [CELL_W-1:0]     pdata;
  logic                  pwe;
  logic [CELL_W-1:0]     pwaddr;
  logic [CELL_W-1:0]     pwdata;
  logic                  wdata;
  logic                  wwe;
  logic [WALL_W-1:0]     wwaddr;
  logic                  wwdata;

  // Remainder unit hookup.
  logic                  rem_start;
  logic                  rem_done;
  logic                  rem_zero;

  logic                  accept;
  logic                  in_range;
  logic                  on_boundary;
  logic                  out_load;

  always_comb begin
    if (32'(grid_side) < 32'd2) begin
      side = SIDE_W'(2);
    end else if (32'(grid_side) > 32'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(grid_side);
    end
  end

  assign side_sq = side * side;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= CFG_W'(RESET_SIDE);
      nn        <= CELL_W'(RESET_SIDE * RESET_SIDE);
      nn2       <= WALL_W'(2 * RESET_SIDE * RESET_SIDE);
      nn2mn     <= WALL_W'(2 * RESET_SIDE * RESET_SIDE - RESET_SIDE);
    end else begin
      if (cfg_wr_en) begin
        grid_side <= cfg_wr_data;
      end
      nn    <= CELL_W'(side_sq);
      nn2   <= WALL_W'({side_sq, 1'b0});
      nn2mn <= WALL_W'({side_sq, 1'b0} - (2*SIDE_W+1)'(side));
    end
  end

  assign s_axis_tready = (state == S_IDLE) && !cfg_wr_en;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rem_start     = accept && (s_axis_tuser == OP_CARVE) && !done_flag;
  assign in_range      = 32'(w) <= 32'(nn2);
  // Zero, right walls of the last column, lower walls of the last row, walls beyond the maze.
  assign on_boundary   = ((32'(w) <= 32'(nn)) && rem_zero) || (32'(w) > 32'(nn2mn));
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  ufmc_rem #(
    .MAX_SIDE (MAX_SIDE)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (s_axis_tdata[WALL_IDX_W-1:0]),
    .divisor  (side),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  // Memory port control. The parent memory reads the walking pointer; it is written
  // during the clearing pass, while compressing a path, and when two roots are linked.
  always_comb begin
    paddr  = (state == S_F2_A || state == S_F2_D) ? cur : root;
    pwe    = 1'b0;
    pwaddr = cur;
    pwdata = root;
    wwe    = 1'b0;
    wwaddr = WALL_W'(w);
    wwdata = 1'b1;
    unique case (state)
      S_CLEAR: begin
        pwe    = 32'(sweep) < CELL_CAP;
        pwaddr = CELL_W'(sweep);
        pwdata = '0;
        wwe    = 1'b1;
        wwaddr = sweep;
        wwdata = (32'(sweep) == 32'(nn));
      end
      S_F2_D: begin
        pwe = 1'b1;
      end
      S_LINK: begin
        pwe    = 1'b1;
        pwaddr = dir ? root : root_a;
        pwdata = dir ? root_a : root;
        wwe    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      parent_mem[pwaddr] <= pwdata;
    end
    pdata <= parent_mem[paddr];
  end

  always_ff @(posedge clk) begin
    if (wwe) begin
      wall_mem[wwaddr] <= wwdata;
    end
    wdata <= wall_mem[WALL_W'(w)];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      pending       <= 1'b0;
      sweep         <= '0;
      join_count    <= '0;
      done_flag     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end

      if (cfg_wr_en) begin
        // A new size restarts the tables.
        state      <= S_CLEAR;
        pending    <= 1'b0;
        sweep      <= '0;
        join_count <= '0;
        done_flag  <= 1'b0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (accept) begin
              unique case (s_axis_tuser)
                OP_RESTART: begin
                  status     <= ST_RESTARTED;
                  pending    <= 1'b1;
                  sweep      <= '0;
                  join_count <= '0;
                  done_flag  <= 1'b0;
                  state      <= S_CLEAR;
                end
                OP_CARVE: begin
                  if (done_flag) begin
                    status <= ST_COMPLETE;
                    state  <= S_WRD;
                  end else begin
                    state <= S_REM;
                  end
                end
                default: begin
                  status <= ST_READ;
                  state  <= S_WRD;
                end
              endcase
            end
          end
          S_CLEAR: begin
            sweep <= sweep + 1'b1;
            if (32'(sweep) == WALL_CAP - 1) begin
              state <= pending ? S_WRD : S_IDLE;
            end
          end
          S_REM: begin
            if (rem_done) begin
              if (on_boundary) begin
                status <= ST_BOUNDARY;
                state  <= S_WRD;
              end else begin
                state <= S_WCHK_A;
              end
            end
          end
          S_WCHK_A: begin
            state <= S_WCHK_D;
          end
          S_WCHK_D: begin
            if (wdata) begin
              status <= ST_OPEN;
              state  <= S_WRD;
            end else begin
              second <= 1'b0;
              if (32'(w) <= 32'(nn)) begin
                cell_start <= CELL_W'(w);
                root       <= CELL_W'(w);
                cell_b     <= CELL_W'(32'(w) + 32'd1);
              end else begin
                cell_start <= CELL_W'(32'(w) - 32'(nn));
                root       <= CELL_W'(32'(w) - 32'(nn));
                cell_b     <= CELL_W'(32'(w) - 32'(nn) + 32'(side));
              end
              state <= S_F1_A;
            end
          end
          S_F1_A: begin
            state <= S_F1_D;
          end
          S_F1_D: begin
            // A zero parent marks a root.
            if (pdata == '0) begin
              cur   <= cell_start;
              state <= S_F2_A;
            end else begin
              root  <= pdata;
              state <= S_F1_A;
            end
          end
          S_F2_A: begin
            if (cur == root) begin
              if (!second) begin
                root_a     <= root;
                second     <= 1'b1;
                cell_start <= cell_b;
                root       <= cell_b;
                state      <= S_F1_A;
              end else if (root_a == root) begin
                status <= ST_SAME_SET;
                state  <= S_WRD;
              end else begin
                state <= S_LINK;
              end
            end else begin
              state <= S_F2_D;
            end
          end
          S_F2_D: begin
            cur   <= pdata;
            state <= S_F2_A;
          end
          S_LINK: begin
            join_count <= join_count + 1'b1;
            if (join_count + 1'b1 == nn - 1'b1) begin
              done_flag <= 1'b1;
            end
            status <= ST_CARVED;
            state  <= S_WRD;
          end
          S_WRD: begin
            state <= S_OUT;
          end
          S_OUT: begin
            if (out_load) begin
              pending <= 1'b0;
              state   <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end

      if (accept) begin
        w   <= s_axis_tdata[WALL_IDX_W-1:0];
        dir <= s_axis_tdata[WALL_IDX_W];
      end
    end
  end

  // Result payload; a wall beyond the maze reads as standing.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {3'b000, done_flag, in_range && wdata, status};
    end
  end
endmodule
`default_nettype wire

FILE: verif/union_find_maze_carver_tb.sv
// Self-checking testbench for the union-find maze carver with its scoreboard class.
`default_nettype none
module union_find_maze_carver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ufmc_pkg::*;

  // The package names three opcodes; the fourth encoding behaves as a read.
  localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;
  localparam int SIDE_CAP = DEFAULT_MAX_SIDE;
  localparam int CELL_SLOTS = SIDE_CAP * SIDE_CAP + 1;
  localparam int WALL_SLOTS = 2 * SIDE_CAP * SIDE_CAP + 1;
  localparam int CYCLE_LIMIT = 20000000;
  // Longest request after the last result, with margin: deep chain walks on big grids.
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                wall_open;
    logic                maze_done;
  } maze_result_t;

  // Scoreboard: a bit-exact maze model plus the queue of results it still owes.
  class maze_scoreboard;
    logic [CFG_W-1:0] side_reg;
    logic [10:0]      parent [CELL_SLOTS];
    bit               wall [WALL_SLOTS];
    int               joins;
    bit               done;
    maze_result_t     pending [$];
    int               errors;

    function int side();
      int n;
      n = int'(side_reg);
      if (n < 2) n = 2;
      if (n > SIDE_CAP) n = SIDE_CAP;
      return n;
    endfunction

    function void clear_maze();
      foreach (parent[i]) parent[i] = '0;
      foreach (wall[i]) wall[i] = 1'b0;
      wall[side() * side()] = 1'b1;
      joins = 0;
      done = 1'b0;
    endfunction

    function void set_side(logic [CFG_W-1:0] v);
      side_reg = v;
      clear_maze();
    endfunction

    // Root lookup that flattens the walked chain onto the root.
    function int root_of(int start_cell);
      int r;
      int cur;
      int nxt;
      if (start_cell >= CELL_SLOTS) return 0;
      r = start_cell;
      while (parent[r] != 0) r = parent[r];
      cur = start_cell;
      while (cur != r && parent[cur] != 0) begin
        nxt = parent[cur];
        parent[cur] = r[10:0];
        cur = nxt;
      end
      return r;
    endfunction

    function bit wall_at_rim(int w, int n);
      int nn;
      nn = n * n;
      return (w <= nn && (w % n) == 0) || w > 2 * nn - n;
    endfunction

    function void note_request(logic [OPC_W-1:0] op, logic [11:0] w, logic dir);
      int n;
      int nn;
      int a;
      int b;
      int ra;
      int rb;
      maze_result_t res;
      n = side();
      nn = n * n;
      if (op == OP_RESTART) begin
        clear_maze();
        res.status = ST_RESTARTED;
      end else if (op == OP_CARVE) begin
        if (done) res.status = ST_COMPLETE;
        else if (wall_at_rim(int'(w), n)) res.status = ST_BOUNDARY;
        else if (wall[w]) res.status = ST_OPEN;
        else begin
          if (int'(w) <= nn) begin
            a = int'(w);
            b = int'(w) + 1;
          end else begin
            a = int'(w) - nn;
            b = a + n;
          end
          ra = root_of(a);
          rb = root_of(b);
          if (ra == rb) res.status = ST_SAME_SET;
          else begin
            if (!dir) parent[ra] = rb[10:0];
            else parent[rb] = ra[10:0];
            wall[w] = 1'b1;
            joins = (joins + 1) & 11'h7ff;
            if (joins == nn - 1) done = 1'b1;
            res.status = ST_CARVED;
          end
        end
      end else begin
        res.status = ST_READ;
      end
      res.wall_open = (int'(w) > 2 * nn) ? 1'b0 : wall[w];
      res.maze_done = done;
      pending.push_back(res);
    endfunction

    function void check_result(logic [7:0] data);
      maze_result_t want;
      maze_result_t got;
      got.status = data[2:0];
      got.wall_open = data[3];
      got.maze_done = data[4];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.wall_open != want.wall_open) begin
        $display("%0t: wall_open expected %0d actual %0d", $time, want.wall_open,
                 got.wall_open);
        errors++;
      end
      if (got.maze_done != want.maze_done) begin
        $display("%0t: maze_done expected %0d actual %0d", $time, want.maze_done,
                 got.maze_done);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [5:0] cfg_wr_data;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;

  maze_scoreboard maze = new();
  // When set, neither side inserts gaps, so back-to-back traffic is exercised.
  bit calm;
  int stall_left;
  int cycles;

  union_find_maze_carver uut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #2 clk = ~clk;

  // Watchdog: the slowest correct run is far below this bound.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check every accepted result, then decide on back-pressure
  // for the following cycle. Stalls are mostly short with a few long ones.
  always @(posedge clk) begin : result_side
    int r;
    if (rst) m_axis_tready <= 1'b0;
    else begin
      if (m_axis_tvalid && m_axis_tready) maze.check_result(m_axis_tdata);
      if (calm) m_axis_tready <= 1'b1;
      else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 20) stall_left <= $urandom_range(1, 3);
        else if (r < 23) stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // Sends one request. When no gap is drawn, tvalid simply stays high and
  // new data is placed on the bus at the edge that took the previous request.
  task automatic send_request(logic [OPC_W-1:0] op, logic [11:0] w, logic dir);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, dir, w};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    maze.note_request(op, w, dir);
  endtask

  // Lets every owed result come back, then gives the block time to settle.
  task automatic drain();
    @(posedge clk);
    s_axis_tvalid <= 1'b0;
    while (maze.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A size change is only made once the block is idle and ready again.
  task automatic write_side(logic [5:0] v);
    drain();
    while (!s_axis_tready) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    maze.set_side(v);
  endtask

  // Random traffic for one maze size. Most requests carve walls inside the
  // grid so mazes actually complete; a finished maze is usually restarted.
  task automatic random_phase(int count);
    int n;
    int r;
    logic [11:0] w;
    n = maze.side();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 999);
      w = 12'($urandom_range(1, 2 * n * n));
      if (maze.done && $urandom_range(0, 2) == 0)
        send_request(OP_RESTART, w, 1'b0);
      else if (r < 850) send_request(OP_CARVE, w, 1'($urandom_range(0, 1)));
      else if (r < 890) send_request(OP_CARVE, 12'($urandom), 1'($urandom_range(0, 1)));
      else if (r < 960)
        send_request(OP_READ,
                     12'((r & 1) ? $urandom : $urandom_range(0, 2 * n * n + 2)),
                     1'($urandom_range(0, 1)));
      else if (r < 995) send_request(OP_SPARE, 12'($urandom), 1'($urandom_range(0, 1)));
      else send_request(OP_RESTART, 12'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [5:0] sides [10] = '{6'd0, 6'd2, 6'd63, 6'd3, 6'd5, 6'd1, 6'd6, 6'd32,
                              6'd8, 6'd4};
    int counts [10] = '{110, 130, 60, 150, 170, 120, 170, 60, 210, 150};
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_CARVE;
    calm = 1'b0;
    stall_left = 0;
    cycles = 0;
    maze.errors = 0;
    maze.set_side(6'(RESET_SIDE));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset size of four: out-of-range and zero walls,
    // right and bottom boundaries, the open exit wall, a repeat carve,
    // a join of cells already in one set, reads, the spare opcode, restart.
    send_request(OP_CARVE, 12'd0, 1'b0);
    send_request(OP_CARVE, 12'hfff, 1'b1);
    send_request(OP_CARVE, 12'd4, 1'b0);
    send_request(OP_CARVE, 12'd16, 1'b0);
    send_request(OP_CARVE, 12'd31, 1'b0);
    send_request(OP_CARVE, 12'd1, 1'b0);
    send_request(OP_CARVE, 12'd1, 1'b1);
    send_request(OP_CARVE, 12'd17, 1'b1);
    send_request(OP_CARVE, 12'd18, 1'b0);
    send_request(OP_CARVE, 12'd5, 1'b1);
    send_request(OP_READ, 12'd1, 1'b0);
    send_request(OP_READ, 12'd16, 1'b1);
    send_request(OP_READ, 12'd0, 1'b0);
    send_request(OP_READ, 12'd33, 1'b0);
    send_request(OP_SPARE, 12'h800, 1'b1);
    send_request(OP_RESTART, 12'd1, 1'b0);
    send_request(OP_READ, 12'd1, 1'b0);

    // Calm stretch first so a whole small maze completes with no gaps.
    calm = 1'b1;
    random_phase(40);
    calm = 1'b0;

    foreach (sides[k]) begin
      write_side(sides[k]);
      calm = (k % 4 == 3);
      random_phase(counts[k]);
    end
    calm = 1'b0;

    drain();
    if (maze.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

FILE: union_find_maze_carver.f
sv/ufmc_pkg.sv
sv/ufmc_rem.sv
sv/union_find_maze_carver.sv
verif/union_find_maze_carver_tb.sv
